### hdl/nfa_pkg.sv
package nfa_pkg;

	localparam int DEF_MAX_SLOTS = 1024;
	localparam int WORD_W = 32;
	localparam int WORD_BITS = 5;

	localparam int SLOT_COUNT_W = 11;
	localparam int STRIDE_W = 13;
	localparam int BASE_W = 64;
	localparam int FREE_IDX_W = 10;
	localparam int SLOT_IDX_W = 10;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CPU_BASE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GPU_BASE = 2'd3;

	localparam logic [SLOT_COUNT_W-1:0] RST_SLOT_COUNT = 11'd1024;
	localparam logic [STRIDE_W-1:0] RST_STRIDE = 13'd32;

	typedef enum logic [STATUS_W-1:0] {
		ST_ALLOC = 2'd0,
		ST_FULL = 2'd1,
		ST_FREED = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_START,
		S_SCAN,
		S_FREE,
		S_MUL,
		S_RESP
	} state_t;

	typedef struct packed {
		logic clear_step;
		logic take;
		logic start;
		logic scan;
		logic free_op;
		logic mul;
		logic load;
	} nfa_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic is_free;
		logic full;
		logic hit;
		logic last_visit;
		logic out_free;
	} nfa_stat_t;

	function automatic logic [WORD_BITS-1:0] first_index(input logic [WORD_W-1:0] onehot);
		logic [WORD_BITS-1:0] idx;
		idx = '0;
		for (int j = 0; j < WORD_W; j++) begin
			for (int k = 0; k < WORD_BITS; k++) begin
				if (j[k]) begin
					idx[k] = idx[k] | onehot[j];
				end
			end
		end
		return idx;
	endfunction

endpackage

### hdl/nfa_ifs.sv
interface nfa_req_if import nfa_pkg::*; ();
	logic valid;
	logic ready;
	logic req_type;
	logic [FREE_IDX_W-1:0] free_index;
	logic owner_match;

	modport source (output valid, req_type, free_index, owner_match, input ready);
	modport sink (input valid, req_type, free_index, owner_match, output ready);
endinterface

interface nfa_rsp_if import nfa_pkg::*; ();
	logic valid;
	logic ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_IDX_W-1:0] slot_index;
	logic [BASE_W-1:0] cpu_handle;
	logic [BASE_W-1:0] gpu_handle;

	modport source (output valid, status, slot_index, cpu_handle, gpu_handle, input ready);
	modport sink (input valid, status, slot_index, cpu_handle, gpu_handle, output ready);
endinterface

interface nfa_cfg_if import nfa_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### hdl/next_fit_bitmap_slot_allocator.sv
// Channel  Role    Payload
// req      sink    req_type, free_index, owner_match
// rsp      source  status, slot_index, cpu_handle, gpu_handle
// cfg      sink    index, data (always ready)
//
// An allocate reads 32-bit flag words in its search loop, one per cycle, from 1 to
// ceil(n / 32) + 1 of them, with n the slot count capped at MAX_SLOTS; a search that
// finds a slot then computes the handles before its result is loaded.
// A free reads and updates one flag word, and a refusal for a full count skips the search.
// After reset a clearing pass writes ceil(MAX_SLOTS / 32) flag words, one per cycle, before
// the first item is accepted. A stalled result holds the output register, and the block
// accepts the next item while it waits.
module next_fit_bitmap_slot_allocator import nfa_pkg::*; #(
	parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
	input logic clk,
	input logic arst_n,
	nfa_req_if.sink req,
	nfa_rsp_if.source rsp,
	nfa_cfg_if.sink cfg
);

	nfa_cmd_t cmd;
	nfa_stat_t stat;
	logic in_ready;

	assign req.ready = in_ready;
	assign cfg.ready = 1'b1;

	nfa_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(req.valid),
		.in_ready(in_ready),
		.stat(stat),
		.cmd(cmd)
	);

	nfa_dp #(
		.MAX_SLOTS(MAX_SLOTS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.in_req_type(req.req_type),
		.in_free_index(req.free_index),
		.in_owner_match(req.owner_match),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.out_status(rsp.status),
		.out_slot_index(rsp.slot_index),
		.out_cpu_handle(rsp.cpu_handle),
		.out_gpu_handle(rsp.gpu_handle),
		.cfg_valid(cfg.valid),
		.cfg_index(cfg.index),
		.cfg_data(cfg.data)
	);

endmodule

### hdl/nfa_ctrl.sv
module nfa_ctrl import nfa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input nfa_stat_t stat,
	output nfa_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (stat.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d = S_START;
				end
			end
			S_START: begin
				cmd.start = 1'b1;
				if (stat.is_free) begin
					state_d = S_FREE;
				end else if (stat.full) begin
					state_d = S_RESP;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.hit) begin
					state_d = S_MUL;
				end else if (stat.last_visit) begin
					state_d = S_RESP;
				end
			end
			S_FREE: begin
				cmd.free_op = 1'b1;
				state_d = S_RESP;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// A new item is only taken once the previous one has been handed to the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take) |=> (state_q == S_START && !in_ready))
		else $error("item taken while another is in progress");

endmodule

### hdl/nfa_dp.sv
module nfa_dp import nfa_pkg::*; #(
	parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
	input logic clk,
	input logic arst_n,
	input nfa_cmd_t cmd,
	output nfa_stat_t stat,
	input logic in_req_type,
	input logic [FREE_IDX_W-1:0] in_free_index,
	input logic in_owner_match,
	output logic out_valid,
	input logic out_ready,
	output logic [STATUS_W-1:0] out_status,
	output logic [SLOT_IDX_W-1:0] out_slot_index,
	output logic [BASE_W-1:0] out_cpu_handle,
	output logic [BASE_W-1:0] out_gpu_handle,
	input logic cfg_valid,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int NW = (MAX_SLOTS + WORD_W - 1) / WORD_W;
	localparam int WAW = (NW > 1) ? $clog2(NW) : 1;
	localparam int PW = WAW + WORD_BITS + 1;
	localparam int MW = STRIDE_W + PW;
	localparam logic [WAW-1:0] LAST_WORD = WAW'(NW - 1);

	logic [SLOT_COUNT_W-1:0] slot_count_q;
	logic [STRIDE_W-1:0] stride_q;
	logic [BASE_W-1:0] cpu_base_q;
	logic [BASE_W-1:0] gpu_base_q;

	logic [WORD_W-1:0] flags_mem [NW];
	logic [WORD_W-1:0] rd_q;
	logic [WAW-1:0] rd_addr;
	logic wr_en;
	logic [WAW-1:0] wr_addr;
	logic [WORD_W-1:0] wr_data;

	logic type_q;
	logic [FREE_IDX_W-1:0] fidx_q;
	logic owner_q;
	logic fidx_ok_q;
	logic [PW-1:0] used_q;
	logic [PW-1:0] next_q;
	logic [WAW-1:0] word_q;
	logic [WORD_BITS-1:0] off_q;
	logic [PW-1:0] visit_q;
	logic [PW-1:0] cp_q;
	status_t res_q;
	logic [MW-1:0] off_s1;
	logic [WAW-1:0] clr_addr_q;
	logic out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_IDX_W-1:0] slot_index_q;
	logic [BASE_W-1:0] cpu_handle_q;
	logic [BASE_W-1:0] gpu_handle_q;

	logic [PW-1:0] eff;
	logic [PW-1:0] nwu;
	logic [PW-1:0] start_pos;
	logic [WAW-1:0] start_word;
	logic [WAW-1:0] free_word;
	logic [PW-1:0] word_base;
	logic [PW-1:0] rem;
	logic [WORD_W-1:0] lim_mask;
	logic [WORD_W-1:0] start_mask;
	logic [WORD_W-1:0] free_bits;
	logic [WORD_W-1:0] low_bit;
	logic hit;
	logic [PW-1:0] hit_idx;
	logic [WAW:0] word_inc;
	logic [WAW-1:0] next_word;
	logic free_ok;

	always_comb begin
		eff = (32'(slot_count_q) > MAX_SLOTS) ? PW'(MAX_SLOTS) : PW'(slot_count_q);
		nwu = (eff + PW'(WORD_W - 1)) >> WORD_BITS;
		start_pos = (next_q >= eff) ? '0 : next_q;
		start_word = start_pos[WORD_BITS +: WAW];
		free_word = fidx_ok_q ? WAW'(fidx_q >> WORD_BITS) : '0;
		word_base = {1'b0, word_q, WORD_BITS'(0)};
		rem = eff - word_base;
		lim_mask = (rem >= PW'(WORD_W)) ? '1
			: ((WORD_W'(1) << rem[WORD_BITS-1:0]) - WORD_W'(1));
		start_mask = {WORD_W{1'b1}} << off_q;
		free_bits = ~rd_q & lim_mask & ((visit_q == '0) ? start_mask : '1);
		low_bit = free_bits & (~free_bits + WORD_W'(1));
		hit = |free_bits;
		hit_idx = {1'b0, word_q, first_index(low_bit)};
		word_inc = {1'b0, word_q} + (WAW + 1)'(1);
		next_word = ({word_inc, WORD_BITS'(0)} >= eff) ? '0 : word_inc[WAW-1:0];
		free_ok = fidx_ok_q && owner_q && (used_q != '0) && rd_q[off_q];
	end

	always_comb begin
		if (cmd.start) begin
			rd_addr = type_q ? free_word : start_word;
		end else begin
			rd_addr = next_word;
		end
		wr_en = 1'b0;
		wr_addr = word_q;
		wr_data = rd_q;
		if (cmd.clear_step) begin
			wr_en = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else if (cmd.scan && hit) begin
			wr_en = 1'b1;
			wr_data = rd_q | low_bit;
		end else if (cmd.free_op && free_ok) begin
			wr_en = 1'b1;
			wr_data = rd_q & ~(WORD_W'(1) << off_q);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			flags_mem[wr_addr] <= wr_data;
		end
		rd_q <= flags_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			type_q <= in_req_type;
			fidx_q <= in_free_index;
			owner_q <= in_owner_match;
			fidx_ok_q <= (32'(in_free_index) < MAX_SLOTS);
		end
		if (cmd.start) begin
			word_q <= rd_addr;
			off_q <= type_q ? fidx_q[WORD_BITS-1:0] : start_pos[WORD_BITS-1:0];
			visit_q <= '0;
			res_q <= ST_FULL;
		end
		if (cmd.scan) begin
			if (hit) begin
				cp_q <= hit_idx;
				res_q <= ST_ALLOC;
			end else begin
				word_q <= next_word;
				visit_q <= visit_q + PW'(1);
			end
		end
		if (cmd.free_op) begin
			res_q <= free_ok ? ST_FREED : ST_IGNORED;
		end
		if (cmd.mul) begin
			off_s1 <= MW'(stride_q) * MW'(cp_q);
		end
		if (cmd.load) begin
			status_q <= res_q;
			if (res_q == ST_ALLOC) begin
				slot_index_q <= SLOT_IDX_W'(cp_q);
				cpu_handle_q <= cpu_base_q + BASE_W'(off_s1);
				gpu_handle_q <= gpu_base_q + BASE_W'(off_s1);
			end else begin
				slot_index_q <= '0;
				cpu_handle_q <= '0;
				gpu_handle_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= RST_SLOT_COUNT;
			stride_q <= RST_STRIDE;
			cpu_base_q <= '0;
			gpu_base_q <= '0;
			used_q <= '0;
			next_q <= '0;
			clr_addr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_SLOT_COUNT: slot_count_q <= cfg_data[SLOT_COUNT_W-1:0];
					REG_STRIDE: stride_q <= cfg_data[STRIDE_W-1:0];
					REG_CPU_BASE: cpu_base_q <= cfg_data[BASE_W-1:0];
					REG_GPU_BASE: gpu_base_q <= cfg_data[BASE_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.scan && hit) begin
				used_q <= used_q + PW'(1);
				next_q <= hit_idx + PW'(1);
			end else if (cmd.free_op && free_ok) begin
				used_q <= used_q - PW'(1);
			end
			if (cmd.clear_step) begin
				clr_addr_q <= clr_addr_q + WAW'(1);
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.clear_last = (clr_addr_q == LAST_WORD);
		stat.is_free = type_q;
		stat.full = (used_q >= eff);
		stat.hit = hit;
		stat.last_visit = (visit_q == nwu);
		stat.out_free = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_status = status_q;
	assign out_slot_index = slot_index_q;
	assign out_cpu_handle = cpu_handle_q;
	assign out_gpu_handle = gpu_handle_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan && hit) |-> (hit_idx < eff))
		else $error("allocated slot lies beyond the slot count");

	assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= PW'(MAX_SLOTS))
		else $error("used count exceeds the built depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> (visit_q <= nwu))
		else $error("search ran past one full lap of the bitmap");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!out_valid_q || out_ready))
		else $error("output register overwritten while still held");

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

module tb import nfa_pkg::*; ();

	localparam int SLOTS = DEF_MAX_SLOTS;

	typedef struct packed {
		status_t st;
		logic [SLOT_IDX_W-1:0] slot;
		logic [BASE_W-1:0] cpu;
		logic [BASE_W-1:0] gpu;
	} answer_t;

	class alloc_tracker;
		bit in_use [SLOTS];
		int next_pos;
		int used;
		logic [SLOT_COUNT_W-1:0] slot_count;
		logic [STRIDE_W-1:0] stride;
		logic [BASE_W-1:0] cpu_base;
		logic [BASE_W-1:0] gpu_base;
		answer_t pending_answers [$];
		int errors;
		int seen [4];
		int reg_writes;

		function new();
			foreach (in_use[i]) in_use[i] = 1'b0;
			next_pos = 0;
			used = 0;
			slot_count = RST_SLOT_COUNT;
			stride = RST_STRIDE;
			cpu_base = '0;
			gpu_base = '0;
			errors = 0;
			reg_writes = 0;
			foreach (seen[i]) seen[i] = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			reg_writes++;
			case (idx)
				REG_SLOT_COUNT: slot_count = data[SLOT_COUNT_W-1:0];
				REG_STRIDE: stride = data[STRIDE_W-1:0];
				REG_CPU_BASE: cpu_base = data;
				REG_GPU_BASE: gpu_base = data;
				default: ;
			endcase
		endfunction

		function int pending();
			return pending_answers.size();
		endfunction

		function int pick_in_use();
			int start;
			start = $urandom_range(0, SLOTS - 1);
			for (int k = 0; k < SLOTS; k++) begin
				if (in_use[(start + k) % SLOTS]) return (start + k) % SLOTS;
			end
			return -1;
		endfunction

		function void note_request(logic rt, logic [FREE_IDX_W-1:0] fi, logic own);
			answer_t a;
			int n;
			int cp;
			bit found;
			logic [BASE_W-1:0] off;
			a = '0;
			if (rt == 1'b0) begin
				n = (slot_count > SLOTS) ? SLOTS : slot_count;
				a.st = ST_FULL;
				if (used < n) begin
					cp = (next_pos >= n) ? 0 : next_pos;
					found = 1'b0;
					for (int i = 0; i < n && !found; i++) begin
						if (!in_use[cp]) begin
							found = 1'b1;
						end else begin
							cp++;
							if (cp >= n) cp = 0;
						end
					end
					if (found) begin
						in_use[cp] = 1'b1;
						next_pos = cp + 1;
						used++;
						off = 64'(stride) * 64'(cp);
						a.st = ST_ALLOC;
						a.slot = 10'(cp);
						a.cpu = cpu_base + off;
						a.gpu = gpu_base + off;
					end
				end
			end else if (own && used != 0 && in_use[fi]) begin
				in_use[fi] = 1'b0;
				used--;
				a.st = ST_FREED;
			end else begin
				a.st = ST_IGNORED;
			end
			pending_answers = {pending_answers, a};
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			end
		endfunction

		function void check_answer(logic [STATUS_W-1:0] st, logic [SLOT_IDX_W-1:0] slot,
				logic [BASE_W-1:0] cpu, logic [BASE_W-1:0] gpu);
			answer_t a;
			if (pending_answers.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual status %0d slot %0d",
					$time, st, slot);
			end else begin
				a = pending_answers.pop_front();
				seen[a.st]++;
				compare_field("status", 64'(a.st), 64'(st));
				compare_field("slot_index", 64'(a.slot), 64'(slot));
				compare_field("cpu_handle", a.cpu, cpu);
				compare_field("gpu_handle", a.gpu, gpu);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit calm = 1'b0;
	int hold_off = 0;
	alloc_tracker tracker = new();

	nfa_req_if req_ch ();
	nfa_rsp_if rsp_ch ();
	nfa_cfg_if cfg_ch ();

	next_fit_bitmap_slot_allocator #(
		.MAX_SLOTS(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source),
		.cfg(cfg_ch.sink)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int draw_wait();
		return calm ? 0 : $urandom_range(0, 9);
	endfunction

	task automatic send_item(input logic rt, input logic [FREE_IDX_W-1:0] fi, input logic own);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= rt;
		req_ch.free_index <= fi;
		req_ch.owner_match <= own;
		do @(posedge clk); while (!req_ch.ready);
		tracker.note_request(rt, fi, own);
	endtask

	task automatic alloc_slot();
		send_item(1'b0, 10'($urandom), 1'($urandom));
	endtask

	task automatic free_slot(input int idx, input logic own);
		send_item(1'b1, 10'(idx), own);
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [3:0] which, input logic [63:0] sc,
			input logic [63:0] st, input logic [63:0] cb, input logic [63:0] gb);
		logic [63:0] vals [4];
		vals = '{sc, st, cb, gb};
		for (int r = 0; r < 4; r++) begin
			if (which[r]) begin
				cfg_ch.valid <= 1'b1;
				cfg_ch.index <= CFG_IDX_W'(r);
				cfg_ch.data <= vals[r];
				do @(posedge clk); while (!cfg_ch.ready);
				tracker.write_reg(CFG_IDX_W'(r), vals[r]);
			end
		end
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		int stall;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off > 0) begin
				stall = hold_off;
				hold_off = 0;
			end else begin
				stall = draw_wait();
			end
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			tracker.check_answer(rsp_ch.status, rsp_ch.slot_index, rsp_ch.cpu_handle,
				rsp_ch.gpu_handle);
		end
	end

	initial begin
		logic [63:0] sc, st, cb, gb;
		int alloc_pct;
		int victim;
		req_ch.valid <= 1'b0;
		req_ch.req_type <= 1'b0;
		req_ch.free_index <= '0;
		req_ch.owner_match <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_SLOT_COUNT;
		cfg_ch.data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: next-fit order, ownership and double-free checks.
		repeat (3) alloc_slot();
		free_slot(1, 1'b0);
		free_slot(1, 1'b1);
		free_slot(1, 1'b1);
		free_slot(SLOTS - 1, 1'b1);
		alloc_slot();
		settle();

		// Slot count above the built depth, widest stride, handles that wrap.
		apply_settings(4'b1111, 64'd2047, 64'd8191, '1, 64'h8000_0000_0000_0000);
		alloc_slot();
		settle();

		// Count lowered below live slots: full refusal, free above the count,
		// search restart from slot zero.
		apply_settings(4'b0011, 64'd4, 64'd4096, '0, '0);
		alloc_slot();
		free_slot(4, 1'b1);
		alloc_slot();
		alloc_slot();
		for (int i = 0; i < 4; i++) free_slot(i, 1'b1);
		free_slot(0, 1'b1);
		settle();

		// No slots at all, then a single slot that wraps onto itself.
		apply_settings(4'b0001, 64'd0, '0, '0, '0);
		alloc_slot();
		settle();
		apply_settings(4'b0001, 64'd1, '0, '0, '0);
		alloc_slot();
		alloc_slot();
		free_slot(0, 1'b1);
		alloc_slot();
		free_slot(SLOTS - 1, 1'b1);
		settle();

		for (int p = 0; p < 12; p++) begin
			case ($urandom_range(0, 9))
				0: sc = 64'd1;
				1: sc = 64'd2;
				2: sc = 64'($urandom_range(3, 40));
				3: sc = 64'd32;
				4: sc = 64'd33;
				5: sc = 64'd1024;
				6: sc = 64'd0;
				7: sc = 64'($urandom_range(1025, 2047));
				8: sc = 64'($urandom_range(41, 200));
				default: sc = 64'd64;
			endcase
			sc = ({$urandom, $urandom} & ~64'h7FF) | sc;
			case ($urandom_range(0, 4))
				0: st = 64'd0;
				1: st = 64'd4096;
				2: st = 64'd8191;
				3: st = 64'd32;
				default: st = {$urandom, $urandom};
			endcase
			case ($urandom_range(0, 2))
				0: cb = '0;
				1: cb = '1;
				default: cb = {$urandom, $urandom};
			endcase
			case ($urandom_range(0, 2))
				0: gb = '0;
				1: gb = '1;
				default: gb = {$urandom, $urandom};
			endcase
			apply_settings((p == 0) ? 4'b1111 : 4'($urandom_range(1, 15)), sc, st, cb, gb);
			calm = (p % 4 == 1);
			if (p == 2) hold_off = 300;
			alloc_pct = $urandom_range(40, 75);
			for (int k = 0; k < 36; k++) begin
				if ($urandom_range(0, 99) < alloc_pct) begin
					alloc_slot();
				end else begin
					victim = tracker.pick_in_use();
					if (victim >= 0 && $urandom_range(0, 9) < 8)
						free_slot(victim, 1'b1);
					else
						free_slot($urandom_range(0, SLOTS - 1), 1'($urandom));
				end
			end
			settle();
		end

		repeat (40) @(posedge clk);
		$display("Ran %0d requests over %0d register writes.",
			tracker.seen[0] + tracker.seen[1] + tracker.seen[2] + tracker.seen[3],
			tracker.reg_writes);
		$display("Outcomes: %0d allocated, %0d refused full, %0d freed, %0d ignored.",
			tracker.seen[ST_ALLOC], tracker.seen[ST_FULL], tracker.seen[ST_FREED],
			tracker.seen[ST_IGNORED]);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timed out with %0d results outstanding.", tracker.pending());
		$display("status: fail");
		$finish;
	end

endmodule

### sim.f
hdl/nfa_pkg.sv
hdl/nfa_ifs.sv
hdl/nfa_ctrl.sv
hdl/nfa_dp.sv
hdl/next_fit_bitmap_slot_allocator.sv
dv/tb.sv
